### hw/rtl/oqkr_pkg.sv
package oqkr_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS = 32;
   localparam int IdxWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_APPEND   = 2'd0,
      CMD_POP_HEAD = 2'd1,
      CMD_POP_KEY  = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic [7:0]           status;
      logic [TIME_BITS-1:0] arrival;
      logic [TIME_BITS-1:0] service;
   } entry_type;

   function automatic logic [TIME_BITS-1:0] to_stamp(input logic [31:0] value);
      logic [63:0] wide;
      wide = 64'(value);
      return wide[TIME_BITS-1:0];
   endfunction

   function automatic logic [31:0] from_stamp(input logic [TIME_BITS-1:0] value);
      logic [63:0] wide;
      wide = 64'(value);
      return wide[31:0];
   endfunction

endpackage

### hw/rtl/ordered_queue_keyed_removal.sv
// An append answers with its strobe in the cycle after it is accepted.
// A removal walks the entry store through its single read port: it scans for
// its entry, then shifts the later entries down; an empty queue skips the scan.
// The next word is taken in the cycle of the strobe; the receiver cannot stall.
// Synchronous active-high reset empties the queue and clears the sequencer.
module ordered_queue_keyed_removal (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_status_value,
   input  logic [31:0] req_arrival_stamp,
   input  logic [31:0] req_service_stamp,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic        rsp_dropped,
   output logic [7:0]  rsp_out_status,
   output logic [31:0] rsp_out_arrival,
   output logic [31:0] rsp_out_service,
   output logic [4:0]  rsp_entry_count
);
   import oqkr_pkg::*;

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] idx_ff, idx_in;
   command_type           cmd_ff, cmd_in;
   logic [7:0]            key_ff, key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff, found_in;
   logic                  dropped_ff, dropped_in;
   logic [7:0]            status_ff, status_in;
   logic [31:0]           arrival_ff, arrival_in;
   logic [31:0]           service_ff, service_in;
   logic [4:0]            ecount_ff, ecount_in;

   logic                  wr_en;
   logic [IdxWidth-1:0]   wr_addr;
   entry_type             wr_data;
   logic [IdxWidth-1:0]   rd_addr;
   entry_type             rd_data;
   logic [CountWidth:0]   idx_next;
   logic [CountWidth:0]   idx_skip;
   logic [CountWidth:0]   count_wide;
   logic                  hit;

   oqkr_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      found_ff   <= found_in;
      dropped_ff <= dropped_in;
      status_ff  <= status_in;
      arrival_ff <= arrival_in;
      service_ff <= service_in;
      ecount_ff  <= ecount_in;
   end

   always_comb begin
      idx_next   = {1'b0, idx_ff} + (CountWidth+1)'(1);
      idx_skip   = {1'b0, idx_ff} + (CountWidth+1)'(2);
      count_wide = {1'b0, count_ff};
      hit        = (cmd_ff == CMD_POP_HEAD) || (rd_data.status == key_ff);

      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      found_in     = found_ff;
      dropped_in   = dropped_ff;
      status_in    = status_ff;
      arrival_in   = arrival_ff;
      service_in   = service_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IdxWidth-1:0];
      wr_data      = rd_data;
      rd_addr      = idx_next[IdxWidth-1:0];

      case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (start) begin
               cmd_in     = command_type'(req_command);
               key_in     = req_status_value;
               idx_in     = '0;
               found_in   = 1'b0;
               dropped_in = 1'b0;
               status_in  = '0;
               arrival_in = '0;
               service_in = '0;
               case (req_command)
                  CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CountWidth'(QUEUE_DEPTH)) begin
                        dropped_in = 1'b1;
                     end else begin
                        wr_en           = 1'b1;
                        wr_addr         = count_ff[IdxWidth-1:0];
                        wr_data.status  = req_status_value;
                        wr_data.arrival = to_stamp(req_arrival_stamp);
                        wr_data.service = to_stamp(req_service_stamp);
                        count_in        = count_ff + CountWidth'(1);
                     end
                  end
                  CMD_POP_HEAD, CMD_POP_KEY: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               found_in   = 1'b1;
               status_in  = rd_data.status;
               arrival_in = from_stamp(rd_data.arrival);
               service_in = from_stamp(rd_data.service);
               if (idx_next < count_wide) begin
                  state_in = ST_SHIFT;
               end else begin
                  count_in     = count_ff - CountWidth'(1);
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (idx_next < count_wide) begin
               idx_in = idx_next[CountWidth-1:0];
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            rd_addr = idx_skip[IdxWidth-1:0];
            idx_in  = idx_next[CountWidth-1:0];
            if (idx_skip >= count_wide) begin
               count_in     = count_ff - CountWidth'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ecount_in = rsp_valid_in ? 5'(count_in) : ecount_ff;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_dropped     = dropped_ff;
   assign rsp_out_status  = status_ff;
   assign rsp_out_arrival = arrival_ff;
   assign rsp_out_service = service_ff;
   assign rsp_entry_count = ecount_ff;

endmodule

### hw/rtl/oqkr_store.sv
module oqkr_store (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [oqkr_pkg::IdxWidth-1:0] wr_addr,
   input  oqkr_pkg::entry_type          wr_data,
   input  logic [oqkr_pkg::IdxWidth-1:0] rd_addr,
   output oqkr_pkg::entry_type          rd_data
);
   import oqkr_pkg::*;

   entry_type store_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/oqkr_checker.sv
module oqkr_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_command,
   input logic [7:0]  req_status_value,
   input logic [31:0] req_arrival_stamp,
   input logic [31:0] req_service_stamp,
   input logic        rsp_valid,
   input logic        rsp_found,
   input logic        rsp_dropped,
   input logic [7:0]  rsp_out_status,
   input logic [31:0] rsp_out_arrival,
   input logic [31:0] rsp_out_service,
   input logic [4:0]  rsp_entry_count
);
   import oqkr_pkg::*;

   // An accepted word either answers at once or keeps the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word neither answered nor kept busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("strobe while busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |->
         (!rsp_found && rsp_entry_count == 5'(QUEUE_DEPTH)))
      else $error("drop reported without a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_out_status == 8'd0 && rsp_out_arrival == 32'd0 &&
          rsp_out_service == 32'd0))
      else $error("entry fields set without a found entry");

endmodule

bind ordered_queue_keyed_removal oqkr_checker u_checker (.*);

### tb/ordered_queue_keyed_removal_checker.sv
`timescale 1ns / 1ps

module ordered_queue_keyed_removal_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_status_value,
   input  logic [31:0] req_arrival_stamp,
   input  logic [31:0] req_service_stamp,
   input  logic        rsp_valid,
   input  logic        rsp_found,
   input  logic        rsp_dropped,
   input  logic [7:0]  rsp_out_status,
   input  logic [31:0] rsp_out_arrival,
   input  logic [31:0] rsp_out_service,
   input  logic [4:0]  rsp_entry_count,
   output int          mismatch_count,
   output int          outstanding
);
   import oqkr_pkg::*;

   typedef struct packed {
      logic        found;
      logic        dropped;
      logic [7:0]  status;
      logic [31:0] arrival;
      logic [31:0] service;
      logic [4:0]  count;
   } result_type;

   entry_type  held_entries[$];
   result_type pending_results[$];

   function automatic result_type apply_command(input logic [1:0] cmd, input logic [7:0] key,
         input logic [31:0] arrival, input logic [31:0] service);
      result_type r;
      entry_type  e;
      int         hit;
      r = '0;
      hit = -1;
      case (cmd)
         CMD_APPEND: begin
            if (held_entries.size() >= QUEUE_DEPTH) begin
               r.dropped = 1'b1;
            end else begin
               e.status = key;
               e.arrival = TIME_BITS'(arrival);
               e.service = TIME_BITS'(service);
               held_entries.push_back(e);
            end
         end
         CMD_POP_HEAD: begin
            if (held_entries.size() > 0) begin
               hit = 0;
            end
         end
         CMD_POP_KEY: begin
            for (int i = 0; i < held_entries.size(); i++) begin
               if (held_entries[i].status == key) begin
                  hit = i;
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      if (hit >= 0) begin
         e = held_entries[hit];
         held_entries.delete(hit);
         r.found = 1'b1;
         r.status = e.status;
         r.arrival = 32'(e.arrival);
         r.service = 32'(e.service);
      end
      r.count = 5'(held_entries.size());
      return r;
   endfunction

   function automatic int field_differs(input string label, input logic [31:0] want,
         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      int         errs;
      errs = 0;
      if (reset) begin
         held_entries.delete();
         pending_results.delete();
         mismatch_count <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            seen = {rsp_found, rsp_dropped, rsp_out_status, rsp_out_arrival, rsp_out_service,
                    rsp_entry_count};
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %h", $time, seen);
               errs++;
            end else begin
               want = pending_results.pop_front();
               errs += field_differs("found", 32'(want.found), 32'(seen.found));
               errs += field_differs("dropped", 32'(want.dropped), 32'(seen.dropped));
               errs += field_differs("out_status", 32'(want.status), 32'(seen.status));
               errs += field_differs("out_arrival", want.arrival, seen.arrival);
               errs += field_differs("out_service", want.service, seen.service);
               errs += field_differs("entry_count", 32'(want.count), 32'(seen.count));
            end
         end
         if (start && !busy) begin
            pending_results.push_back(apply_command(req_command, req_status_value,
                                                    req_arrival_stamp, req_service_stamp));
         end
         mismatch_count <= mismatch_count + errs;
         outstanding <= pending_results.size();
      end
   end

endmodule

### tb/ordered_queue_keyed_removal_test.sv
`timescale 1ns / 1ps

module ordered_queue_keyed_removal_test;
   import oqkr_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_command;
   logic [7:0]  req_status_value;
   logic [31:0] req_arrival_stamp;
   logic [31:0] req_service_stamp;
   logic        rsp_valid;
   logic        rsp_found;
   logic        rsp_dropped;
   logic [7:0]  rsp_out_status;
   logic [31:0] rsp_out_arrival;
   logic [31:0] rsp_out_service;
   logic [4:0]  rsp_entry_count;
   int          mismatch_count;
   int          outstanding;
   int          gap_percent;

   ordered_queue_keyed_removal u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_status_value  (req_status_value),
      .req_arrival_stamp (req_arrival_stamp),
      .req_service_stamp (req_service_stamp),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_dropped       (rsp_dropped),
      .rsp_out_status    (rsp_out_status),
      .rsp_out_arrival   (rsp_out_arrival),
      .rsp_out_service   (rsp_out_service),
      .rsp_entry_count   (rsp_entry_count)
   );

   ordered_queue_keyed_removal_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_status_value  (req_status_value),
      .req_arrival_stamp (req_arrival_stamp),
      .req_service_stamp (req_service_stamp),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_dropped       (rsp_dropped),
      .rsp_out_status    (rsp_out_status),
      .rsp_out_arrival   (rsp_out_arrival),
      .rsp_out_service   (rsp_out_service),
      .rsp_entry_count   (rsp_entry_count),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic issue_command(input logic [1:0] cmd, input logic [7:0] key,
         input logic [31:0] arrival, input logic [31:0] service);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < gap_percent) begin
         gap = $urandom_range(1, 14);
      end
      if (gap > 0) begin
         start <= 1'b0;
         req_command <= 2'($urandom());
         req_status_value <= 8'($urandom());
         req_arrival_stamp <= $urandom();
         req_service_stamp <= $urandom();
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_status_value <= key;
      req_arrival_stamp <= arrival;
      req_service_stamp <= service;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_status();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return 8'($urandom_range(0, 7));
      if (roll < 80) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [31:0] pick_stamp();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 32'h0000_0000;
      if (roll < 20) return 32'hFFFF_FFFF;
      return $urandom();
   endfunction

   task automatic issue_random_command(input mix_type mix);
      int         roll;
      int         append_below;
      int         head_below;
      logic [1:0] cmd;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            append_below = 62;
            head_below = 75;
         end
         MIX_DRAIN: begin
            append_below = 25;
            head_below = 55;
         end
         default: begin
            append_below = 45;
            head_below = 68;
         end
      endcase
      if (roll < append_below) begin
         cmd = CMD_APPEND;
      end else if (roll < head_below) begin
         cmd = CMD_POP_HEAD;
      end else if (roll < 97) begin
         cmd = CMD_POP_KEY;
      end else begin
         cmd = CMD_UNUSED;
      end
      issue_command(cmd, pick_status(), pick_stamp(), pick_stamp());
   endtask

   initial begin
      int      waited;
      mix_type mix;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_APPEND;
      req_status_value = 8'h00;
      req_arrival_stamp = 32'h0;
      req_service_stamp = 32'h0;
      gap_percent = 20;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      issue_command(CMD_POP_HEAD, 8'h00, 32'h0, 32'h0);
      issue_command(CMD_POP_KEY, 8'hFF, 32'h0, 32'h0);
      issue_command(CMD_UNUSED, 8'h00, 32'h0, 32'h0);
      issue_command(CMD_APPEND, 8'h00, 32'h0000_0000, 32'h0000_0000);
      issue_command(CMD_POP_KEY, 8'h01, 32'h0, 32'h0);
      issue_command(CMD_POP_KEY, 8'h00, 32'h0, 32'h0);
      issue_command(CMD_APPEND, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         issue_command(CMD_APPEND, 8'(i % 4), $urandom(), $urandom());
      end
      issue_command(CMD_APPEND, 8'h5A, 32'hAAAA_5555, 32'h5555_AAAA);
      issue_command(CMD_UNUSED, 8'hA5, 32'h5555_AAAA, 32'hAAAA_5555);
      issue_command(CMD_POP_KEY, 8'h03, 32'h0, 32'h0);
      issue_command(CMD_POP_KEY, 8'hFF, 32'h0, 32'h0);
      issue_command(CMD_POP_HEAD, 8'h00, 32'h0, 32'h0);

      for (int blk = 0; blk < 21; blk++) begin
         case ($urandom_range(0, 2))
            0: mix = MIX_FILL;
            1: mix = MIX_DRAIN;
            default: mix = MIX_EVEN;
         endcase
         case ($urandom_range(0, 3))
            0: gap_percent = 0;
            1: gap_percent = 10;
            2: gap_percent = 35;
            default: gap_percent = 70;
         endcase
         for (int n = 0; n < 50; n++) begin
            issue_random_command(mix);
         end
      end

      gap_percent = 0;
      for (int n = 0; n < 100; n++) begin
         issue_random_command(n < 50 ? MIX_FILL : MIX_DRAIN);
      end
      start <= 1'b0;

      waited = 0;
      while (outstanding != 0 && waited < 500) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (outstanding != 0) begin
         $display("%0t: %0d result words never arrived", $time, outstanding);
      end
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
